FILE: rtl/ccp_pkg.sv
// ----------------------------------------------------------------------------
// CRC codeword packer package
// Shared constants, register map, configuration and job types.
// ----------------------------------------------------------------------------
package ccp_pkg;

   // Default sizes for the top-level parameters.
   localparam int GEN_MAX_LEN_DEF = 17;
   localparam int COUNT_WIDTH_DEF = 32;

   // The generator length never exceeds this, whatever the parameter says.
   localparam int LEN_HARD_CAP = 17;

   // Register file geometry and field widths.
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int POLY_W      = 17;
   localparam int GLEN_W      = 5;
   localparam int MSG_W       = 32;

   // Depth of the job queue between front and back end.
   localparam int QUEUE_DEPTH_DEF = 2;

   // Pad count field and codeword length field of a job.
   localparam int PAD_W    = 4;
   localparam int CW_LEN_W = 6;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DATAWORD_IS_BYTE = 2'd0,
      CSR_GEN_POLY         = 2'd1,
      CSR_GEN_LENGTH       = 2'd2,
      CSR_MESSAGE_BYTES    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              dataword_is_byte;
      logic [POLY_W-1:0] gen_poly;
      logic [GLEN_W-1:0] gen_length;
      logic [MSG_W-1:0]  message_bytes;
   } cfg_type;

   // Control half of one job handed from the front end to the back end.
   typedef struct packed {
      logic                hdr;
      logic [PAD_W-1:0]    pad;
      logic                eom;
      logic [CW_LEN_W-1:0] cw_len;
   } job_ctl_type;

   // Widest remainder the hardware carries for a given generator limit.
   function automatic int rem_width(input int gen_max_len);
      return ((gen_max_len < LEN_HARD_CAP) ? gen_max_len : LEN_HARD_CAP) - 1;
   endfunction

endpackage

FILE: rtl/ccp_req_if.sv
// ----------------------------------------------------------------------------
// Message byte channel
// Valid/ready channel that carries one message byte per beat.
// ----------------------------------------------------------------------------
interface ccp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: rtl/ccp_rsp_if.sv
// ----------------------------------------------------------------------------
// Packed byte channel
// Valid/ready channel that carries one header or stream byte per beat.
// ----------------------------------------------------------------------------
interface ccp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_header;
   logic       last_of_run;

   modport source (output valid, output out_byte, output is_header,
                   output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input is_header,
                   input last_of_run, output ready);
endinterface

FILE: rtl/ccp_front.sv
// ----------------------------------------------------------------------------
// CRC codeword packer front end
// Accepts message bytes, computes the CRC remainders, builds the codeword
// bits and tracks message boundaries and the header pad.
// ----------------------------------------------------------------------------
module ccp_front #(
   parameter int  GEN_MAX_LEN = ccp_pkg::GEN_MAX_LEN_DEF,
   parameter int  COUNT_WIDTH = ccp_pkg::COUNT_WIDTH_DEF,
   localparam int CW_W        = 8 + 2 * ccp_pkg::rem_width(GEN_MAX_LEN)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ccp_pkg::cfg_type     cfg,
   ccp_req_if.sink              req_if,
   input  logic                 queue_full,
   output logic                 push,
   output ccp_pkg::job_ctl_type push_ctl,
   output logic [CW_W-1:0]      push_cw
);
   import ccp_pkg::*;

   localparam int REM_W  = rem_width(GEN_MAX_LEN);
   localparam int HALF_W = 4 + REM_W;
   localparam int R_W    = $clog2(REM_W + 1);
   localparam int MB_W   = (COUNT_WIDTH < MSG_W) ? COUNT_WIDTH : MSG_W;
   localparam int CMP_W  = (COUNT_WIDTH > MSG_W) ? COUNT_WIDTH : MSG_W;

   // Remainder of one dataword, MSB first; a nibble uses the top four bits.
   function automatic logic [REM_W-1:0] crc_rem(input logic [7:0]       d,
                                                input logic             nibble,
                                                input logic [REM_W-1:0] poly,
                                                input logic [REM_W-1:0] mask,
                                                input logic [REM_W-1:0] top);
      logic [REM_W-1:0] rem;
      logic             fb;
      rem = '0;
      fb  = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!nibble || (i < 4)) begin
            fb  = d[7-i] ^ (|(rem & top));
            rem = (rem << 1) & mask;
            if (fb) begin
               rem = rem ^ poly;
            end
         end
      end
      return rem;
   endfunction

   logic [GLEN_W-1:0]      len_eff;
   logic [R_W-1:0]         r;
   logic [REM_W:0]         one_sh;
   logic [REM_W-1:0]       rmask;
   logic [REM_W-1:0]       topmask;
   logic [REM_W-1:0]       poly;
   logic [REM_W-1:0]       rem_b;
   logic [REM_W-1:0]       rem_hi;
   logic [REM_W-1:0]       rem_lo;
   logic [R_W-1:0]         align;
   logic [HALF_W-1:0]      cw_a;
   logic [HALF_W-1:0]      cw_b;
   logic [CW_W-1:0]        cw_byte;
   logic [CW_W-1:0]        cw_nib;
   logic [CW_LEN_W-1:0]    cw_len;
   logic [MB_W-1:0]        mb_masked;
   logic [CMP_W-1:0]       mb_eff;
   logic [2:0]             mb3;
   logic [5:0]             prod;
   logic [PAD_W-1:0]       pad;
   logic [COUNT_WIDTH-1:0] cnt_next;
   logic                   eom;
   logic                   accept;

   logic [COUNT_WIDTH-1:0] cnt_ff;
   logic [COUNT_WIDTH-1:0] cnt_in;
   logic                   hdr_sent_ff;
   logic                   hdr_sent_in;

   // Handshake: take a byte whenever the queue has room.
   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && !queue_full;
   assign push         = accept;

   // Effective generator length, remainder width and masks.
   always_comb begin
      if (cfg.gen_length > GLEN_W'(REM_W + 1)) begin
         len_eff = GLEN_W'(REM_W + 1);
      end else if (cfg.gen_length == '0) begin
         len_eff = GLEN_W'(1);
      end else begin
         len_eff = cfg.gen_length;
      end
      r       = R_W'(len_eff - GLEN_W'(1));
      one_sh  = (REM_W + 1)'(1) << r;
      rmask   = REM_W'(one_sh - (REM_W + 1)'(1));
      topmask = REM_W'(one_sh >> 1);
      poly    = cfg.gen_poly[REM_W-1:0] & rmask;
   end

   // Remainders for the whole byte and for each nibble.
   assign rem_b  = crc_rem(req_if.data_byte, 1'b0, poly, rmask, topmask);
   assign rem_hi = crc_rem({req_if.data_byte[7:4], 4'b0000}, 1'b1, poly, rmask, topmask);
   assign rem_lo = crc_rem({req_if.data_byte[3:0], 4'b0000}, 1'b1, poly, rmask, topmask);
   assign align  = R_W'(REM_W) - r;

   // Codeword bits left-aligned, the two nibble codewords run together.
   always_comb begin
      cw_byte = {req_if.data_byte, rem_b << align, {REM_W{1'b0}}};
      cw_a    = {req_if.data_byte[7:4], rem_hi << align};
      cw_b    = {req_if.data_byte[3:0], rem_lo << align};
      cw_nib  = {cw_a, {HALF_W{1'b0}}}
              | ({cw_b, {HALF_W{1'b0}}} >> (CW_LEN_W'(r) + CW_LEN_W'(4)));
      if (cfg.dataword_is_byte) begin
         cw_len = CW_LEN_W'(8) + CW_LEN_W'(r);
      end else begin
         cw_len = CW_LEN_W'(8) + CW_LEN_W'(r) + CW_LEN_W'(r);
      end
   end

   // Pad from message length times codeword bits per byte, modulo eight.
   always_comb begin
      mb_masked = cfg.message_bytes[MB_W-1:0];
      if (mb_masked == '0) begin
         mb_eff = CMP_W'(1);
         mb3    = 3'd1;
      end else begin
         mb_eff = CMP_W'(mb_masked);
         mb3    = mb_masked[2:0];
      end
      prod = 6'(mb3) * 6'(cw_len[2:0]);
      pad  = PAD_W'(8) - PAD_W'(prod[2:0]);
   end

   // Message boundary tracking.
   always_comb begin
      cnt_next    = cnt_ff + COUNT_WIDTH'(1);
      eom         = CMP_W'(cnt_next) >= mb_eff;
      cnt_in      = cnt_ff;
      hdr_sent_in = hdr_sent_ff;
      if (accept) begin
         cnt_in      = eom ? '0 : cnt_next;
         hdr_sent_in = !eom;
      end
   end

   // Job handed to the queue.
   always_comb begin
      push_ctl.hdr    = !hdr_sent_ff;
      push_ctl.pad    = pad;
      push_ctl.eom    = eom;
      push_ctl.cw_len = cw_len;
      push_cw         = cfg.dataword_is_byte ? cw_byte : cw_nib;
   end

   // Message state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         hdr_sent_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         hdr_sent_ff <= hdr_sent_in;
      end
   end

endmodule

FILE: rtl/ccp_queue.sv
// ----------------------------------------------------------------------------
// CRC codeword packer job queue
// Small first-in first-out queue that decouples front and back end.
// ----------------------------------------------------------------------------
module ccp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = ccp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);
   import ccp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/ccp_back.sv
// ----------------------------------------------------------------------------
// CRC codeword packer back end
// Merges each job's bits into the held stream bits and sends the header and
// every complete byte, one beat per cycle while the output channel is ready.
// ----------------------------------------------------------------------------
module ccp_back #(
   parameter int  GEN_MAX_LEN = ccp_pkg::GEN_MAX_LEN_DEF,
   localparam int CW_W        = 8 + 2 * ccp_pkg::rem_width(GEN_MAX_LEN)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  ccp_pkg::job_ctl_type job_ctl,
   input  logic [CW_W-1:0]      job_cw,
   output logic                 pop,
   ccp_rsp_if.source            rsp_if
);
   import ccp_pkg::*;

   // Held bits, pad and codeword bits together.
   localparam int WORK_W = 7 + 8 + CW_W;
   localparam int CNT_W  = $clog2(WORK_W + 1);

   logic              active_ff;
   logic              active_in;
   logic              hdr_pend_ff;
   logic              hdr_pend_in;
   logic [PAD_W-1:0]  pad_ff;
   logic [PAD_W-1:0]  pad_in;
   logic              eom_ff;
   logic              eom_in;
   logic [WORK_W-1:0] work_ff;
   logic [WORK_W-1:0] work_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   logic              has_byte;
   logic              last;
   logic              fire;
   logic              done;
   logic              load;
   logic [WORK_W-1:0] keep_work;
   logic [CNT_W-1:0]  keep_cnt;
   logic [CNT_W-1:0]  shamt;

   // Output beat straight from the working registers.
   assign has_byte           = (count_ff >= CNT_W'(8));
   assign last               = hdr_pend_ff ? !has_byte : (count_ff < CNT_W'(16));
   assign rsp_if.valid       = active_ff && (hdr_pend_ff || has_byte);
   assign rsp_if.out_byte    = hdr_pend_ff ? 8'(pad_ff) : work_ff[WORK_W-1 -: 8];
   assign rsp_if.is_header   = hdr_pend_ff;
   assign rsp_if.last_of_run = last;
   assign fire               = rsp_if.valid && rsp_if.ready;

   // A job is finished on its last beat, or at once if it has none.
   assign done = active_ff && ((fire && last) || (!hdr_pend_ff && !has_byte));
   assign load = job_valid && (!active_ff || done);
   assign pop  = load;

   // Stream bits left over after this cycle's beat.
   always_comb begin
      keep_work = work_ff;
      keep_cnt  = count_ff;
      if (fire && !hdr_pend_ff) begin
         keep_work = work_ff << 8;
         keep_cnt  = count_ff - CNT_W'(8);
      end
      if (done && eom_ff) begin
         keep_work = '0;
         keep_cnt  = '0;
      end
   end

   // Next job is appended behind the held bits and, for a header job, its zero pad.
   always_comb begin
      shamt       = keep_cnt + (job_ctl.hdr ? CNT_W'(job_ctl.pad) : '0);
      work_in     = keep_work;
      count_in    = keep_cnt;
      active_in   = active_ff && !done;
      hdr_pend_in = hdr_pend_ff && !fire;
      pad_in      = pad_ff;
      eom_in      = eom_ff;
      if (load) begin
         work_in     = keep_work | ({job_cw, {(WORK_W - CW_W){1'b0}}} >> shamt);
         count_in    = shamt + CNT_W'(job_ctl.cw_len);
         active_in   = 1'b1;
         hdr_pend_in = job_ctl.hdr;
         pad_in      = job_ctl.pad;
         eom_in      = job_ctl.eom;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         hdr_pend_ff <= 1'b0;
         eom_ff      <= 1'b0;
         work_ff     <= '0;
         count_ff    <= '0;
      end else begin
         active_ff   <= active_in;
         hdr_pend_ff <= hdr_pend_in;
         eom_ff      <= eom_in;
         work_ff     <= work_in;
         count_ff    <= count_in;
      end
   end

   // The pad count is payload only.
   always_ff @(posedge clock) begin
      pad_ff <= pad_in;
   end

endmodule

FILE: rtl/crc_codeword_packer_unit.sv
// A byte accepted by the front end passes through the job queue and the back-end registers
// before its first result beat. Result beats leave one per cycle while the result channel
// is ready; a byte gives one to seven beats via the single byte-wide back-end output.
// The front end takes a byte every cycle while the two-entry job queue has room.
// Reset is synchronous: control state clears and the configuration registers return to
// their reset values; queue entries and the held pad count are payload and keep their value.
// ----------------------------------------------------------------------------
// CRC codeword packer unit
// Splits message bytes into datawords, appends CRC remainders and packs the
// codeword stream into bytes behind a pad-count header.
// ----------------------------------------------------------------------------
module crc_codeword_packer_unit #(
   parameter int GEN_MAX_LEN = ccp_pkg::GEN_MAX_LEN_DEF,
   parameter int COUNT_WIDTH = ccp_pkg::COUNT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   ccp_req_if.sink                        req_if,
   ccp_rsp_if.source                      rsp_if,
   input  logic                           csr_write_en,
   input  logic [ccp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ccp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ccp_pkg::*;

   localparam int CW_W  = 8 + 2 * rem_width(GEN_MAX_LEN);
   localparam int JOB_W = $bits(job_ctl_type) + CW_W;

   cfg_type          cfg_ff;
   cfg_type          cfg_in;

   logic             q_push;
   job_ctl_type      push_ctl;
   logic [CW_W-1:0]  push_cw;
   logic             q_full;
   logic             q_not_empty;
   logic             q_pop;
   logic [JOB_W-1:0] q_head;
   job_ctl_type      head_ctl;
   logic [CW_W-1:0]  head_cw;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DATAWORD_IS_BYTE: cfg_in.dataword_is_byte = csr_wdata[0];
            CSR_GEN_POLY:         cfg_in.gen_poly         = csr_wdata[POLY_W-1:0];
            CSR_GEN_LENGTH:       cfg_in.gen_length       = csr_wdata[GLEN_W-1:0];
            CSR_MESSAGE_BYTES:    cfg_in.message_bytes    = csr_wdata[MSG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dataword_is_byte <= 1'b1;
         cfg_ff.gen_poly         <= POLY_W'(13);
         cfg_ff.gen_length       <= GLEN_W'(4);
         cfg_ff.message_bytes    <= MSG_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: byte intake and codeword generation.
   ccp_front #(
      .GEN_MAX_LEN (GEN_MAX_LEN),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_if     (req_if),
      .queue_full (q_full),
      .push       (q_push),
      .push_ctl   (push_ctl),
      .push_cw    (push_cw)
   );

   // Job queue between the two ends.
   ccp_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH_DEF)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_ctl, push_cw}),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_data (q_head)
   );

   assign head_ctl = job_ctl_type'(q_head[JOB_W-1:CW_W]);
   assign head_cw  = q_head[CW_W-1:0];

   // Back end: byte packing and output.
   ccp_back #(
      .GEN_MAX_LEN (GEN_MAX_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_not_empty),
      .job_ctl   (head_ctl),
      .job_cw    (head_cw),
      .pop       (q_pop),
      .rsp_if    (rsp_if)
   );

   // A header beat always carries a pad count of one to eight.
   a_header_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.is_header) |-> (rsp_if.out_byte != 8'd0 && rsp_if.out_byte <= 8'd8))
      else $error("header beat carries a pad count outside one to eight");

   // The front end never writes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("job pushed into a full queue");

   // Nothing is offered in the cycle after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result beat offered straight after reset");

   // A job is only taken from a queue that holds one.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("job taken from an empty queue");

endmodule

FILE: tb/crc_codeword_packer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CRC codeword packer unit testbench
// Drives message bytes and register writes into the packer, predicts every
// header and stream beat with a bit-serial model of the encoder, and checks
// the result channel beat by beat under random idling on both channels.
// ----------------------------------------------------------------------------
module crc_codeword_packer_unit_tb;
   import ccp_pkg::*;

   localparam int GEN_MAX_LEN   = GEN_MAX_LEN_DEF;
   localparam int COUNT_WIDTH   = COUNT_WIDTH_DEF;
   localparam int RANDOM_ITEMS  = 440;
   localparam int DRAIN_CYCLES  = 8;
   localparam int DIRECTED_ROWS = 39;

   // One result beat as it leaves the block.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_header;
      logic       last_of_run;
   } stream_beat_type;

   // One row of the directed part: either a register write or a message byte.
   // Where n_typed is non-zero, the expected beats are given in typed, first
   // beat (always the header) in the top byte.
   typedef struct packed {
      logic          is_write;
      csr_index_type reg_sel;
      logic [31:0]   value;
      logic [7:0]    data_byte;
      logic [1:0]    n_typed;
      logic [23:0]   typed;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ccp_req_if req_ch ();
   ccp_rsp_if rsp_ch ();

   // Shadow registers and encoder state of the predictor.
   cfg_type         shadow_cfg;
   logic [7:0]      stream_bits;
   int              stream_held;
   logic [31:0]     msg_taken;
   bit              msg_open;

   stream_beat_type new_beats[$];
   stream_beat_type beats_due[$];

   bit idle_on;
   int error_count;
   int bytes_sent;
   int beats_checked;
   int settings_run;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // Register values after reset: pad of five, then the bare codeword.
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'h00, 2'd3, 24'h050000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'hFF, 2'd3, 24'h0507FD},
      // Generator of length one and zero: no remainder, pad of eight.
      '{1'b1, CSR_GEN_LENGTH,       32'd1, 8'h00, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'hA5, 2'd3, 24'h0800A5},
      '{1'b1, CSR_GEN_LENGTH,       32'd0, 8'h00, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'h3C, 2'd3, 24'h08003C},
      // Nibble datawords, widest generator, leading term set in the register.
      '{1'b1, CSR_DATAWORD_IS_BYTE, 32'd0, 8'h00, 2'd0, 24'h000000},
      '{1'b1, CSR_GEN_POLY,         32'h1FFFF, 8'h00, 2'd0, 24'h000000},
      '{1'b1, CSR_GEN_LENGTH,       32'd17, 8'h00, 2'd0, 24'h000000},
      '{1'b1, CSR_MESSAGE_BYTES,    32'd3, 8'h00, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'h00, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'hFF, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'h5A, 2'd0, 24'h000000},
      // Length beyond the limit saturates.
      '{1'b1, CSR_GEN_LENGTH,       32'd31, 8'h00, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'hF0, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'h0F, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'hC3, 2'd0, 24'h000000},
      // A zero message length behaves as one byte.
      '{1'b1, CSR_MESSAGE_BYTES,    32'd0, 8'h00, 2'd0, 24'h000000},
      '{1'b1, CSR_GEN_LENGTH,       32'd1, 8'h00, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'h81, 2'd3, 24'h080081},
      // A message that never ends, later cut short by a smaller length.
      '{1'b1, CSR_DATAWORD_IS_BYTE, 32'd1, 8'h00, 2'd0, 24'h000000},
      '{1'b1, CSR_GEN_POLY,         32'd0, 8'h00, 2'd0, 24'h000000},
      '{1'b1, CSR_GEN_LENGTH,       32'd9, 8'h00, 2'd0, 24'h000000},
      '{1'b1, CSR_MESSAGE_BYTES,    32'hFFFFFFFF, 8'h00, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'h01, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'h80, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'h7E, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'hE7, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'h55, 2'd0, 24'h000000},
      '{1'b1, CSR_MESSAGE_BYTES,    32'd2, 8'h00, 2'd0, 24'h000000},
      '{1'b1, CSR_GEN_LENGTH,       32'd2, 8'h00, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'hAA, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'h55, 2'd0, 24'h000000},
      // Shortest real generator over a four-byte message.
      '{1'b1, CSR_GEN_POLY,         32'd1, 8'h00, 2'd0, 24'h000000},
      '{1'b1, CSR_MESSAGE_BYTES,    32'd4, 8'h00, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'h36, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'hC9, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'h00, 2'd0, 24'h000000},
      '{1'b0, CSR_DATAWORD_IS_BYTE, 32'd0, 8'hFF, 2'd0, 24'h000000}
   };

   crc_codeword_packer_unit #(
      .GEN_MAX_LEN (GEN_MAX_LEN),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_ch),
      .rsp_if       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Free-running clock, 20 ns period.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit on the run, far beyond the slowest legal schedule.
   initial begin
      #10_000_000;
      $display("Timeout at %0t with %0d beats still expected.", $time, beats_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Cycles a side waits before its next beat; none during burst phases.
   function automatic int draw_gap();
      return idle_on ? $urandom_range(0, 7) : 0;
   endfunction

   function automatic void add_beat(input logic [7:0] value, input logic hdr);
      stream_beat_type beat;
      beat.out_byte    = value;
      beat.is_header   = hdr;
      beat.last_of_run = 1'b0;
      if (new_beats.size() < 8)
         new_beats.push_back(beat);
   endfunction

   // Appends one bit to the stream and emits a byte once eight are held.
   function automatic void push_stream_bit(input logic b);
      stream_bits = {stream_bits[6:0], b};
      stream_held++;
      if (stream_held >= 8) begin
         add_beat(stream_bits, 1'b0);
         stream_bits = '0;
         stream_held = 0;
      end
   endfunction

   // Sends a dataword MSB first while dividing it by the generator, then
   // sends the remainder.
   function automatic void push_codeword(input logic [7:0] word, input int width,
                                         input int rem_w, input logic [15:0] poly);
      logic [15:0] rem;
      logic [15:0] rem_mask;
      logic        fb;
      int          i;
      rem      = '0;
      rem_mask = 16'((32'd1 << rem_w) - 1);
      for (i = width - 1; i >= 0; i--) begin
         push_stream_bit(word[i]);
         if (rem_w > 0) begin
            fb  = word[i] ^ rem[rem_w-1];
            rem = (rem << 1) & rem_mask;
            if (fb)
               rem = rem ^ poly;
         end
      end
      for (i = rem_w - 1; i >= 0; i--)
         push_stream_bit(rem[i]);
   endfunction

   // Works out every beat that one accepted message byte gives.
   function automatic void encode_byte(input logic [7:0] value);
      int          gen_len;
      int          rem_w;
      int          bits_per_byte;
      int          pad;
      logic [15:0] poly;
      logic [31:0] msg_len;
      new_beats.delete();
      gen_len = shadow_cfg.gen_length;
      if (gen_len > GEN_MAX_LEN)
         gen_len = GEN_MAX_LEN;
      if (gen_len > LEN_HARD_CAP)
         gen_len = LEN_HARD_CAP;
      if (gen_len < 1)
         gen_len = 1;
      rem_w = gen_len - 1;
      poly  = shadow_cfg.gen_poly[15:0] & 16'((32'd1 << rem_w) - 1);

      msg_len = shadow_cfg.message_bytes;
      if (msg_len == 0)
         msg_len = 1;

      // First byte of a message: header with the pad count, then the pad.
      if (!msg_open) begin
         bits_per_byte = shadow_cfg.dataword_is_byte ? 8 + rem_w : 8 + 2 * rem_w;
         pad = 8 - ((int'(msg_len[2:0]) * (bits_per_byte % 8)) % 8);
         add_beat(8'(pad), 1'b1);
         repeat (pad) push_stream_bit(1'b0);
         msg_open = 1'b1;
      end

      if (shadow_cfg.dataword_is_byte) begin
         push_codeword(value, 8, rem_w, poly);
      end else begin
         push_codeword({4'h0, value[7:4]}, 4, rem_w, poly);
         push_codeword({4'h0, value[3:0]}, 4, rem_w, poly);
      end

      // End of message: count and header flag clear, leftover bits are lost.
      msg_taken = msg_taken + 1;
      if (msg_taken >= msg_len) begin
         msg_taken   = '0;
         msg_open    = 1'b0;
         stream_bits = '0;
         stream_held = 0;
      end

      if (new_beats.size() > 0)
         new_beats[new_beats.size()-1].last_of_run = 1'b1;
   endfunction

   // One register write, also applied to the shadow copy.
   task automatic write_register(input csr_index_type sel, input logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= sel;
      csr_wdata    <= value;
      case (sel)
         CSR_DATAWORD_IS_BYTE: shadow_cfg.dataword_is_byte = value[0];
         CSR_GEN_POLY:         shadow_cfg.gen_poly         = value[POLY_W-1:0];
         CSR_GEN_LENGTH:       shadow_cfg.gen_length       = value[GLEN_W-1:0];
         CSR_MESSAGE_BYTES:    shadow_cfg.message_bytes    = value[MSG_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every expected beat has arrived and the block has gone quiet.
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      while (beats_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Offers one message byte and queues its expected beats once accepted.
   task automatic send_byte(input logic [7:0] value, input logic [1:0] n_typed,
                            input logic [23:0] typed);
      int              gap;
      int              k;
      stream_beat_type beat;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= value;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));

      encode_byte(value);
      // Rows with typed results replace the predicted beats.
      if (n_typed != 0) begin
         new_beats.delete();
         for (k = 0; k < n_typed; k++) begin
            beat.out_byte    = typed[23 - 8 * k -: 8];
            beat.is_header   = (k == 0);
            beat.last_of_run = (k == n_typed - 1);
            new_beats.push_back(beat);
         end
      end
      foreach (new_beats[j])
         beats_due.push_back(new_beats[j]);
      bytes_sent++;
   endtask

   // Result side: random stalls, then each accepted beat is checked against
   // the oldest expectation.
   initial begin
      int              stall;
      stream_beat_type seen;
      stream_beat_type want;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         seen.out_byte    = rsp_ch.out_byte;
         seen.is_header   = rsp_ch.is_header;
         seen.last_of_run = rsp_ch.last_of_run;
         if (beats_due.size() == 0) begin
            error_count++;
            $display("%0t: unexpected beat: out_byte=%02h is_header=%0b last_of_run=%0b",
                     $time, seen.out_byte, seen.is_header, seen.last_of_run);
         end else begin
            want = beats_due.pop_front();
            beats_checked++;
            if (seen.out_byte !== want.out_byte || seen.is_header !== want.is_header ||
                seen.last_of_run !== want.last_of_run) begin
               error_count++;
               $display("%0t: mismatch: expected out_byte=%02h is_header=%0b last_of_run=%0b,",
                        $time, want.out_byte, want.is_header, want.last_of_run);
               $display("%0t:           actual   out_byte=%02h is_header=%0b last_of_run=%0b",
                        $time, seen.out_byte, seen.is_header, seen.last_of_run);
            end
         end
      end
   end

   // Stimulus: reset, directed rows, then random register settings and messages.
   initial begin
      int          random_left;
      int          n_items;
      int unsigned msg_len;
      logic [31:0] value;
      logic [7:0]  data;
      int          directed_bytes;

      reset            <= 1'b1;
      csr_write_en     <= 1'b0;
      csr_index        <= CSR_DATAWORD_IS_BYTE;
      csr_wdata        <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= '0;
      shadow_cfg  = '{1'b1, 17'd13, 5'd4, 32'd1};
      stream_bits = '0;
      stream_held = 0;
      msg_taken   = '0;
      msg_open    = 1'b0;
      idle_on     = 1'b1;
      error_count   = 0;
      bytes_sent    = 0;
      beats_checked = 0;
      settings_run  = 1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: registers change only once the block has drained.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].is_write) begin
            settle_block();
            write_register(directed_rows[r].reg_sel, directed_rows[r].value);
            settings_run++;
         end else begin
            send_byte(directed_rows[r].data_byte, directed_rows[r].n_typed,
                      directed_rows[r].typed);
         end
      end
      directed_bytes = bytes_sent;

      // Random part: each phase picks new settings, mostly whole messages.
      random_left = RANDOM_ITEMS;
      while (random_left > 0) begin
         settle_block();
         if ($urandom_range(0, 3) != 0)
            write_register(CSR_DATAWORD_IS_BYTE, $urandom_range(0, 1));
         if ($urandom_range(0, 3) != 0)
            write_register(CSR_GEN_POLY, $urandom_range(0, 17'h1FFFF));
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0:       value = $urandom_range(18, 31);
               1:       value = 0;
               default: value = $urandom_range(1, 17);
            endcase
            write_register(CSR_GEN_LENGTH, value);
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0:       value = 0;
               1:       value = $urandom();
               default: value = $urandom_range(1, 6);
            endcase
            write_register(CSR_MESSAGE_BYTES, value);
         end
         settings_run++;
         idle_on = ($urandom_range(0, 3) != 0);

         msg_len = (shadow_cfg.message_bytes == 0) ? 1 : shadow_cfg.message_bytes;
         n_items = (msg_len <= 8) ? int'(msg_len) * $urandom_range(2, 6)
                                  : $urandom_range(5, 30);
         if (n_items > random_left)
            n_items = random_left;
         repeat (n_items) begin
            case ($urandom_range(0, 7))
               0:       data = 8'h00;
               1:       data = 8'hFF;
               default: data = $urandom_range(0, 255);
            endcase
            send_byte(data, 2'd0, 24'd0);
         end
         random_left -= n_items;
      end

      // Let the last beats through, then watch for stray ones.
      settle_block();
      repeat (4 * DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d message bytes (%0d directed) under %0d register settings;",
               bytes_sent, directed_bytes, settings_run);
      $display("checked %0d result beats, %0d failures.", beats_checked, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
